@@ design/lzw_pkg.sv @@
`default_nettype none
package lzw_pkg;
	localparam int DICT_ENTRIES  = 4096;
	localparam int MAX_CODE_BITS = 12;
	localparam int DICT_AW = $clog2(DICT_ENTRIES);
	localparam int CODE_W  = DICT_AW;
	localparam int NFC_W   = DICT_AW + 1;
	localparam int KEY_W   = CODE_W + 8;
	localparam int HASH_AW = DICT_AW + 1;
	localparam int DICT_W  = HASH_AW + KEY_W;
	localparam int FIRST_FREE = 256;

	typedef struct packed {
		logic       valid;
		logic [7:0] in_byte;
		logic       last_byte;
	} lzw_item_t;

	function automatic logic [3:0] width_for(input logic [NFC_W-1:0] n);
		logic [3:0] r;
		r = 4'(MAX_CODE_BITS);
		for (int w = MAX_CODE_BITS; w >= 8; w--) begin
			if ({1'b0, n} <= ((NFC_W+1)'(1) << w)) begin
				r = 4'(w);
			end
		end
		return r;
	endfunction

	function automatic logic [HASH_AW-1:0] hash_of(input logic [CODE_W-1:0] p,
			input logic [7:0] b);
		return (HASH_AW'(b) << (HASH_AW - 8)) ^ HASH_AW'(p);
	endfunction
endpackage
`default_nettype wire

@@ design/lzw_ram.sv @@
`default_nettype none
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/lzw_front.sv @@
`default_nettype none
module lzw_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hold,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,
	input  wire logic              s_axis_tlast,
	output lzw_pkg::lzw_item_t     item,
	input  wire logic              pop
);
	import lzw_pkg::*;

	logic [8:0] slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, take;

	assign s_axis_tready = (cnt_q != 2'd2) && !hold;
	assign push = s_axis_tvalid && s_axis_tready;
	assign take = pop && (cnt_q != 2'd0);

	assign item.valid     = (cnt_q != 2'd0);
	assign item.in_byte   = slot_q[rd_q][8:1];
	assign item.last_byte = slot_q[rd_q][0];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= {s_axis_tdata, s_axis_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(take);
		end
	end
endmodule
`default_nettype wire

@@ design/lzw_back.sv @@
`default_nettype none
module lzw_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lzw_pkg::lzw_item_t item,
	output logic                   pop,
	output logic                   clearing,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [15:0]            m_axis_tdata,
	output logic                   m_axis_tlast
);
	import lzw_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SLOT, S_CHECK, S_VERIFY, S_MISS, S_FINAL
	} state_t;

	state_t             state_q;
	logic [HASH_AW-1:0] clr_q, h_q;
	logic [CODE_W-1:0]  prefix_q, cand_q;
	logic               have_q, last_q;
	logic [7:0]         b_q;
	logic [NFC_W-1:0]   nfc_q;

	logic               h_we, d_we, out_free, emit;
	logic [HASH_AW-1:0] h_waddr;
	logic [CODE_W-1:0]  h_wdata, h_rdata;
	logic [KEY_W-1:0]   key;
	logic [DICT_W-1:0]  d_rdata;
	logic               slot_empty, dict_room;

	assign key       = {prefix_q, b_q};
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign emit      = ((state_q == S_MISS) || (state_q == S_FINAL)) && out_free;
	assign dict_room = (nfc_q < NFC_W'(DICT_ENTRIES));
	assign slot_empty = (h_rdata < CODE_W'(FIRST_FREE)) || (NFC_W'(h_rdata) >= nfc_q);
	assign clearing  = (state_q == S_CLEAR);
	assign pop       = (state_q == S_IDLE) && item.valid;

	always_comb begin
		h_we    = 1'b0;
		h_waddr = h_q;
		h_wdata = nfc_q[CODE_W-1:0];
		d_we    = 1'b0;
		if (state_q == S_CLEAR) begin
			h_we    = 1'b1;
			h_waddr = clr_q;
			h_wdata = '0;
		end else if (state_q == S_MISS && out_free && dict_room) begin
			h_we = 1'b1;
			d_we = 1'b1;
		end
	end

	lzw_ram #(.WIDTH(CODE_W), .DEPTH(1 << HASH_AW)) u_hash (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_q), .rdata(h_rdata)
	);

	// Each entry also records the index slot that points at it, so a slot
	// left over from an earlier stream is recognized as free.
	lzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict (
		.clk(clk), .we(d_we), .waddr(nfc_q[DICT_AW-1:0]), .wdata({h_q, key}),
		.raddr(h_rdata[DICT_AW-1:0]), .rdata(d_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			h_q           <= '0;
			prefix_q      <= '0;
			cand_q        <= '0;
			have_q        <= 1'b0;
			last_q        <= 1'b0;
			b_q           <= '0;
			nfc_q         <= NFC_W'(FIRST_FREE);
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (emit) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item.valid) begin
						b_q    <= item.in_byte;
						last_q <= item.last_byte;
						if (!have_q) begin
							prefix_q <= CODE_W'(item.in_byte);
							have_q   <= 1'b1;
							if (item.last_byte) state_q <= S_FINAL;
						end else begin
							h_q     <= hash_of(prefix_q, item.in_byte);
							state_q <= S_SLOT;
						end
					end
				end
				S_SLOT: state_q <= S_CHECK;
				S_CHECK: begin
					if (slot_empty) begin
						state_q <= S_MISS;
					end else begin
						cand_q  <= h_rdata;
						state_q <= S_VERIFY;
					end
				end
				S_VERIFY: begin
					if (d_rdata[DICT_W-1:KEY_W] != h_q) begin
						state_q <= S_MISS;
					end else if (d_rdata[KEY_W-1:0] == key) begin
						prefix_q <= cand_q;
						state_q  <= last_q ? S_FINAL : S_IDLE;
					end else begin
						h_q     <= h_q + 1'b1;
						state_q <= S_SLOT;
					end
				end
				S_MISS: begin
					if (out_free) begin
						m_axis_tdata  <= {width_for(nfc_q), 12'(prefix_q)};
						m_axis_tlast  <= 1'b0;
						if (dict_room) nfc_q <= nfc_q + 1'b1;
						prefix_q <= CODE_W'(b_q);
						state_q  <= last_q ? S_FINAL : S_IDLE;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						m_axis_tdata  <= {width_for(nfc_q), 12'(prefix_q)};
						m_axis_tlast  <= 1'b1;
						prefix_q <= '0;
						have_q   <= 1'b0;
						nfc_q    <= NFC_W'(FIRST_FREE);
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/lzw_encoder.sv @@
`default_nettype none
// LZW compressor taking one byte per beat and producing variable-width codes.
// A small input queue takes bytes while the engine behind it searches a hashed
// index of the dictionary with linear probing. The first byte of a stream is
// simply taken as the prefix. Any other byte is accepted, its index slot is
// read and checked, and then either the dictionary entry is compared or, on
// an empty slot, the prefix code is emitted; each further probe repeats the
// read, check and compare, and a slot left over from an earlier stream needs
// the compare as well. The last byte of a stream passes through a final step
// to flush the final code, and a code waiting for the receiver stalls the
// engine only when the next code is ready. The index has twice as many slots
// as the dictionary has entries, so chains stay short. After reset a clearing
// pass sweeps the index, one entry per cycle, and no byte is taken until it
// ends. At the end of each stream the dictionary restarts at once with no
// further sweep: a slot counts only if its code is below the next free code
// and that dictionary entry names the slot back. Results leave through an
// output register, so the engine keeps working while a code waits.
module lzw_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // in_byte[7:0]
	input  wire logic        s_axis_tlast,  // last_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // code[11:0], code_bits[15:12]
	output logic             m_axis_tlast   // end_of_stream
);
	import lzw_pkg::*;

	lzw_item_t item;
	logic      pop, clearing;

	// The queue holds bytes until the engine is ready for them.
	lzw_front u_front (
		.clk(clk), .arst_n(arst_n), .hold(clearing),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.item(item), .pop(pop)
	);

	// The engine does lookup, insertion and code output.
	lzw_back u_back (
		.clk(clk), .arst_n(arst_n), .item(item), .pop(pop), .clearing(clearing),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);
endmodule
`default_nettype wire

@@ verif/tb_lzw_encoder.sv @@
`timescale 1ns / 100ps
`default_nettype none
// Bench for the LZW encoder. Bytes go in as beats on the slave side while a
// scoreboard runs its own dictionary to work out the codes that must come
// out on the master side, in order, with their widths and the end marker.
module tb_lzw_encoder;
	import lzw_pkg::*;

	// One expected code beat.
	typedef struct {
		logic [11:0] code;
		logic [3:0]  code_bits;
		logic        eos;
	} code_beat_t;

	// Scoreboard that keeps its own copy of the compressor state. The
	// dictionary is a flat table of keys; searches run in order of code.
	class lzw_scoreboard;
		logic [19:0] dict_keys[4096];
		logic [11:0] cur_prefix;
		bit          holding;
		int unsigned free_code;
		code_beat_t  pending[$];
		int unsigned errors;

		function void restart();
			cur_prefix = '0;
			holding    = 0;
			free_code  = FIRST_FREE;
		endfunction

		function logic [3:0] bits_for(int unsigned entries);
			int unsigned w;
			w = 0;
			while (w < 31 && (32'd1 << w) < entries)
				w++;
			if (w > MAX_CODE_BITS)
				w = MAX_CODE_BITS;
			return 4'(w);
		endfunction

		function void push_code(logic [11:0] c, bit eos);
			code_beat_t e;
			e.code      = c;
			e.code_bits = bits_for(free_code);
			e.eos       = eos;
			pending.insert(pending.size(), e);
		endfunction

		// Note a byte accepted by the block and queue the codes it causes.
		function void note_byte(logic [7:0] b, bit last);
			logic [19:0] key;
			int          found;
			found = -1;
			if (!holding) begin
				cur_prefix = 12'(b);
				holding    = 1;
			end else begin
				key = {cur_prefix, b};
				for (int c = FIRST_FREE; c < free_code && c < DICT_ENTRIES; c++) begin
					if (dict_keys[c] == key) begin
						found = c;
						break;
					end
				end
				if (found >= 0) begin
					cur_prefix = 12'(found);
				end else begin
					push_code(cur_prefix, 0);
					if (free_code < DICT_ENTRIES) begin
						dict_keys[free_code] = key;
						free_code++;
					end
					cur_prefix = 12'(b);
				end
			end
			if (last) begin
				push_code(cur_prefix, 1);
				restart();
			end
		endfunction

		// Compare one code beat from the block with the oldest expectation.
		function void check_code(logic [15:0] data, logic tlast);
			code_beat_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected code beat data=%h last=%b", $time, data, tlast);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[11:0] !== e.code) begin
				$display("%0t: code expected %h actual %h", $time, e.code, data[11:0]);
				errors++;
			end
			if (data[15:12] !== e.code_bits) begin
				$display("%0t: code_bits expected %0d actual %0d", $time,
					e.code_bits, data[15:12]);
				errors++;
			end
			if (tlast !== e.eos) begin
				$display("%0t: end_of_stream expected %b actual %b", $time, e.eos, tlast);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // in_byte[7:0]
	logic        s_axis_tlast;   // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // code[11:0], code_bits[15:12]
	logic        m_axis_tlast;   // end_of_stream

	lzw_scoreboard sb;
	longint unsigned cycle_count;
	bit          sending_done;
	int          stall_mode;

	lzw_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// The generous limit covers the clearing sweep plus every byte under the
	// heaviest stalls on both sides, several times over.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd400000) begin
			$display("tb_lzw_encoder: FAIL");
			$finish;
		end
	end

	// Results are checked at the edge where the beat is taken, using the
	// values the block drove before that edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_code(m_axis_tdata, m_axis_tlast);
	end

	// The receiver cycles through phases: always ready, light stalls, and
	// heavy stalls, each for a random stretch.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Send one byte; valid stays high across back-to-back beats and is only
	// lowered by an explicit gap.
	task automatic send_byte(input logic [7:0] b, input bit last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(b, last);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	int burst_left;

	// Each call is one beat of a random burst schedule.
	task automatic send_paced(input logic [7:0] b, input bit last);
		if (burst_left == 0) begin
			idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_byte(b, last);
	endtask

	// A stream drawn from a small alphabet repeats often and builds deep
	// chains of learned codes; a wide alphabet mostly misses.
	task automatic send_stream(input int len, input int alpha, input int base);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'(base + $urandom_range(0, alpha - 1));
			send_paced(b, i == len - 1);
		end
	endtask

	int sent;
	int len;

	initial begin
		sb = new();
		sb.restart();
		sb.errors     = 0;
		cycle_count   = 0;
		sending_done  = 0;
		stall_mode    = 0;
		burst_left    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a lone byte as its own stream, the byte extremes, a
		// repeated pair that hits, and a miss on the last byte.
		send_byte(8'h00, 1);
		send_byte(8'hFF, 1);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 1);
		send_byte(8'hAA, 0);
		send_byte(8'hAA, 0);
		send_byte(8'hAA, 0);
		send_byte(8'hAA, 0);
		send_byte(8'h55, 1);
		send_byte(8'h41, 0);
		send_byte(8'h42, 0);
		send_byte(8'h41, 0);
		send_byte(8'h42, 0);
		send_byte(8'h41, 0);
		send_byte(8'h42, 1);
		send_byte(8'h01, 0);
		send_byte(8'h80, 0);
		send_byte(8'h7F, 0);
		send_byte(8'hFE, 1);
		sent = 19;

		// Random streams of mixed length and alphabet size.
		while (sent < 450) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
			case ($urandom_range(0, 2))
				0: send_stream(len, $urandom_range(1, 4), $urandom_range(0, 252));
				1: send_stream(len, $urandom_range(5, 32), $urandom_range(0, 200));
				default: send_stream(len, 256, 0);
			endcase
			sent += len;
		end

		// One longer stream of wide random bytes, which mostly misses and
		// grows the codes to eleven bits.
		for (int i = 0; i < 900; i++)
			send_paced(8'($urandom_range(0, 255)), i == 899);

		// A few short streams afterwards to confirm a fresh start.
		for (int k = 0; k < 6; k++)
			send_stream($urandom_range(1, 30), $urandom_range(1, 8), $urandom_range(0, 240));

		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_lzw_encoder: PASS");
		else
			$display("tb_lzw_encoder: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/lzw_pkg.sv
design/lzw_ram.sv
design/lzw_front.sv
design/lzw_back.sv
design/lzw_encoder.sv
verif/tb_lzw_encoder.sv
